>>> rtl/bfsp_pkg.sv
// Shared constants, types and command struct for the fan step PWM core.
package bfsp_pkg;

  // Field widths
  localparam int STEP_W   = 12;
  localparam int MAG_W    = 11;
  localparam int TRIM_W   = 10;
  localparam int INC_W    = 8;
  localparam int DUTY_W   = 8;
  localparam int PROD1_W  = MAG_W + INC_W;
  localparam int PROD2_W  = PROD1_W + TRIM_W;

  // Stream widths
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_WIRE_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_INC  = 1'd1;

  // Arithmetic constants
  localparam int TRIM_GRANULE    = 16;
  localparam int TRIM_FULL_SCALE = 1024;
  localparam int TRIM_SHIFT      = $clog2(TRIM_FULL_SCALE);
  localparam int STEP_LIMIT      = 2047;
  localparam int DUTY_MAX        = 255;

  localparam logic [TRIM_W-1:0] TRIM_MASK = ~TRIM_W'(TRIM_GRANULE - 1);

  // Reset values
  localparam logic [INC_W-1:0]  STEP_INC_RESET  = 8'd15;
  localparam logic [TRIM_W-1:0] LAST_TRIM_RESET = 10'd1023;

  // Wire modes
  localparam logic MODE_TWO_WIRE   = 1'b0;
  localparam logic MODE_THREE_WIRE = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic update;
  } bfsp_cmd_t;

endpackage

>>> rtl/bfsp_ctrl.sv
// Controller state machine sequencing one press request through the datapath.
module bfsp_ctrl
  import bfsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output bfsp_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL1 = 2'd1;
  localparam logic [1:0] S_MUL2 = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       slot_free;

  // The output register is free once its request has been taken.
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1 = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (slot_free) begin
          cmd.update = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.update) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // At most one datapath command is issued in any cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.mul1, cmd.mul2, cmd.update}))
    else $error("more than one datapath command at once");

  // A loaded request is always followed by the first multiply.
  assert property (@(posedge clk) disable iff (!rst_n) cmd.load |=> cmd.mul1)
    else $error("first multiply did not follow the load");

  // An update always presents a result in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n) cmd.update |=> out_valid_r)
    else $error("update did not present a result");

endmodule

>>> rtl/bfsp_datapath.sv
// Datapath: configuration, step and trim state, two multiplies and the result register.
module bfsp_datapath
  import bfsp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [IN_DATA_W-1:0]   in_tdata,
  input  bfsp_cmd_t              cmd,
  output logic [OUT_DATA_W-1:0]  out_tdata
);

  // Configuration registers
  logic              wire_mode_r;
  logic [INC_W-1:0]  step_inc_r;

  // Persistent state
  logic signed [STEP_W-1:0] speed_step_r;
  logic signed [STEP_W-1:0] speed_step_nxt;
  logic [TRIM_W-1:0]        last_trim_r;
  logic [DUTY_W-1:0]        fwd_duty_r;
  logic [DUTY_W-1:0]        fwd_duty_nxt;
  logic [DUTY_W-1:0]        rev_duty_r;
  logic [DUTY_W-1:0]        rev_duty_nxt;

  // Working registers
  logic signed [STEP_W-1:0] next_r;
  logic [TRIM_W-1:0]        trim_r;
  logic [PROD1_W-1:0]       prod1_r;
  logic [PROD2_W-1:0]       prod2_r;

  // Result register fields
  logic              o_fwd_en_r;
  logic              o_rev_en_r;
  logic              o_hard_en_r;
  logic              o_rej_r;

  // Input fields
  logic              press_forward;
  logic [TRIM_W-1:0] trim_sample;
  logic              trim_valid;

  logic [TRIM_W-1:0]        trim_sel;
  logic signed [STEP_W:0]   step_sum;
  logic signed [STEP_W-1:0] next_step;
  logic [MAG_W-1:0]         next_abs;
  logic [DUTY_W-1:0]        mag;
  logic                     reject;

  assign press_forward = in_tdata[0];
  assign trim_sample   = in_tdata[TRIM_W:1];
  assign trim_valid    = in_tdata[TRIM_W+1];

  // Trim selection: a usable nonzero sample is floored to the granule; otherwise the last trim is reused.
  always_comb begin
    if (trim_valid && (trim_sample != '0)) begin
      trim_sel = trim_sample & TRIM_MASK;
    end else begin
      trim_sel = last_trim_r;
    end
  end

  // Step move with saturation and the three-wire floor at zero.
  always_comb begin
    step_sum = {speed_step_r[STEP_W-1], speed_step_r}
             + (press_forward ? (STEP_W+1)'(signed'(1)) : -(STEP_W+1)'(signed'(1)));
    if (step_sum > (STEP_W+1)'(STEP_LIMIT)) begin
      next_step = STEP_W'(STEP_LIMIT);
    end else if (step_sum < -(STEP_W+1)'(STEP_LIMIT)) begin
      next_step = -STEP_W'(STEP_LIMIT);
    end else begin
      next_step = step_sum[STEP_W-1:0];
    end
    if ((wire_mode_r == MODE_THREE_WIRE) && next_step[STEP_W-1]) begin
      next_step = '0;
    end
  end

  // Magnitude of the stepped value
  always_comb begin
    if (next_r[STEP_W-1]) begin
      next_abs = MAG_W'(-next_r);
    end else begin
      next_abs = next_r[MAG_W-1:0];
    end
  end

  // Duty scaling by the full scale and the overflow check
  assign reject = (prod2_r >> TRIM_SHIFT) > PROD2_W'(DUTY_MAX);
  assign mag    = prod2_r[TRIM_SHIFT +: DUTY_W];

  // State update for an accepted press
  always_comb begin
    speed_step_nxt = speed_step_r;
    fwd_duty_nxt   = fwd_duty_r;
    rev_duty_nxt   = rev_duty_r;
    if (!reject) begin
      speed_step_nxt = next_r;
      if (wire_mode_r == MODE_TWO_WIRE) begin
        if (!next_r[STEP_W-1]) begin
          fwd_duty_nxt = mag;
          rev_duty_nxt = '0;
        end else begin
          fwd_duty_nxt = '0;
          rev_duty_nxt = mag;
        end
      end else begin
        rev_duty_nxt = mag;
      end
    end
  end

  // Configuration and persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wire_mode_r  <= MODE_TWO_WIRE;
      step_inc_r   <= STEP_INC_RESET;
      speed_step_r <= '0;
      last_trim_r  <= LAST_TRIM_RESET;
      fwd_duty_r   <= '0;
      rev_duty_r   <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_WIRE_MODE: wire_mode_r <= cfg_data[0];
          REG_STEP_INC:  step_inc_r  <= cfg_data[INC_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        last_trim_r <= trim_sel;
      end
      if (cmd.update) begin
        speed_step_r <= speed_step_nxt;
        fwd_duty_r   <= fwd_duty_nxt;
        rev_duty_r   <= rev_duty_nxt;
      end
    end
  end

  // Working registers and the result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      next_r <= next_step;
      trim_r <= trim_sel;
    end
    if (cmd.mul1) begin
      prod1_r <= PROD1_W'(next_abs) * PROD1_W'(step_inc_r);
    end
    if (cmd.mul2) begin
      prod2_r <= PROD2_W'(prod1_r) * PROD2_W'(trim_r);
    end
    if (cmd.update) begin
      o_fwd_en_r  <= (wire_mode_r == MODE_TWO_WIRE) && (speed_step_nxt > 0);
      o_rev_en_r  <= ((wire_mode_r == MODE_TWO_WIRE) && speed_step_nxt[STEP_W-1])
                  || ((wire_mode_r == MODE_THREE_WIRE) && (speed_step_nxt > 0));
      o_hard_en_r <= (wire_mode_r == MODE_THREE_WIRE) && (speed_step_nxt > 0);
      o_rej_r     <= reject;
    end
  end

  assign out_tdata = {4'b0000, o_rej_r, o_hard_en_r, o_rev_en_r, o_fwd_en_r,
                      rev_duty_r, fwd_duty_r};

  // The step never leaves the saturation range.
  assert property (@(posedge clk) disable iff (!rst_n)
    speed_step_r != -STEP_W'(STEP_LIMIT + 1))
    else $error("speed step below the saturation limit");

  // A rejected press leaves the step unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && reject) |=> $stable(speed_step_r))
    else $error("rejected press moved the step");

endmodule

>>> rtl/bidirectional_fan_step_pwm_core.sv
// Top level of the bidirectional fan speed-step PWM core.
//
//  Channel  | Direction | Handshake              | Contents
//  ---------+-----------+------------------------+------------------------------------
//  in_      | input     | in_tvalid / in_tready  | one press request
//  out_     | output    | out_tvalid / out_tready| duties, enables and reject flag
//  cfg_     | input     | cfg_valid / cfg_ready  | register index and write data
//
// Each request passes through four steps: load, scale by the increment, scale by the trim,
// and update; the two dependent multiplies in the shared datapath fix that order.
// A new request is taken only while the controller is idle; a finished result
// waits in the output register while the next request is loaded and worked on.
// A stalled output holds the update step until the register is free.
// Reset is synchronous and active low; configuration writes are always taken.
module bidirectional_fan_step_pwm_core
  import bfsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // [0] press_forward, [10:1] trim_sample, [11] trim_valid, [15:12] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [7:0] forward_duty, [15:8] reverse_duty, [16] forward_enable,
  // [17] reverse_enable, [18] hard_enable, [19] rejected, [23:20] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  bfsp_cmd_t cmd;

  // Configuration is accepted in every cycle.
  assign cfg_ready = 1'b1;

  bfsp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  bfsp_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .out_tdata (out_tdata)
  );

endmodule

>>> test/bidirectional_fan_step_pwm_core_tb.sv
// Self-checking testbench for the bidirectional fan speed-step PWM core.
module bidirectional_fan_step_pwm_core_tb;
  import bfsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam bit PRESS_FWD = 1'b1;
  localparam bit PRESS_REV = 1'b0;

  // One press request, packed as it travels in in_tdata (lowest field last here).
  typedef struct packed {
    logic              trim_valid;
    logic [TRIM_W-1:0] trim_sample;
    logic              press_forward;
  } press_t;

  // Fan outputs, packed as they travel in out_tdata[19:0].
  typedef struct packed {
    logic              rejected;
    logic              hard_en;
    logic              rev_en;
    logic              fwd_en;
    logic [DUTY_W-1:0] rev_duty;
    logic [DUTY_W-1:0] fwd_duty;
  } fan_outputs_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the core's registers and state
  logic              mode_sel = MODE_TWO_WIRE;
  logic [INC_W-1:0]  inc_sel = STEP_INC_RESET;
  int                step_now = 0;
  logic [TRIM_W-1:0] trim_held = LAST_TRIM_RESET;
  logic [DUTY_W-1:0] fwd_duty_now = '0;
  logic [DUTY_W-1:0] rev_duty_now = '0;

  press_t       pending_presses[$];
  fan_outputs_t expected_outputs[$];
  press_t       press_on_bus;
  int           presses_queued = 0;
  int           presses_taken = 0;
  int           outputs_checked = 0;
  int           fail_count = 0;
  int           reported = 0;
  int           rx_hold_left = 0;
  bit           rx_hold_done = 1'b0;

  bidirectional_fan_step_pwm_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // Advances the shadow state by one press and returns the outputs it should show.
  function automatic fan_outputs_t apply_press(press_t p);
    int                nxt;
    longint            mag;
    logic [TRIM_W-1:0] trim;
    fan_outputs_t      o;
    // A zero or timed-out reading falls back on the last trim used.
    if (p.trim_valid && p.trim_sample != '0) trim = p.trim_sample & TRIM_MASK;
    else trim = trim_held;
    nxt = step_now + ((p.press_forward == PRESS_FWD) ? 1 : -1);
    if (nxt > STEP_LIMIT) nxt = STEP_LIMIT;
    if (nxt < -STEP_LIMIT) nxt = -STEP_LIMIT;
    if (mode_sel == MODE_THREE_WIRE && nxt < 0) nxt = 0;
    mag = longint'(nxt < 0 ? -nxt : nxt) * longint'(inc_sel) * longint'(trim);
    mag = mag / TRIM_FULL_SCALE;
    // The trim is kept even when the press is turned away.
    trim_held = trim;
    o.rejected = (mag > DUTY_MAX);
    if (!o.rejected) begin
      step_now = nxt;
      if (mode_sel == MODE_THREE_WIRE) begin
        rev_duty_now = DUTY_W'(mag);
      end else if (nxt >= 0) begin
        fwd_duty_now = DUTY_W'(mag);
        rev_duty_now = '0;
      end else begin
        fwd_duty_now = '0;
        rev_duty_now = DUTY_W'(mag);
      end
    end
    o.fwd_duty = fwd_duty_now;
    o.rev_duty = rev_duty_now;
    o.fwd_en   = (mode_sel == MODE_TWO_WIRE) && step_now > 0;
    o.rev_en   = ((mode_sel == MODE_TWO_WIRE) && step_now < 0) ||
                 ((mode_sel == MODE_THREE_WIRE) && step_now > 0);
    o.hard_en  = (mode_sel == MODE_THREE_WIRE) && step_now > 0;
    return o;
  endfunction

  // Press driver: holds a request until it is taken, otherwise offers the next one.
  always @(posedge clk) begin
    bit busy;
    bit quiet;
    busy = in_tvalid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_outputs.push_back(apply_press(press_on_bus));
        presses_taken++;
        busy = 1'b0;
      end
      if (!busy) begin
        quiet = (presses_taken % 1000) >= 700 && (presses_taken % 1000) < 900;
        if (pending_presses.size() > 0 && (quiet || $urandom_range(99) >= 37)) begin
          press_on_bus = pending_presses.pop_front();
          in_tdata  <= IN_DATA_W'(press_on_bus);
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each result against the oldest prediction and paces out_tready.
  always @(posedge clk) begin
    fan_outputs_t got;
    fan_outputs_t want;
    bit           quiet;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(fan_outputs_t)-1:0];
      if (expected_outputs.size() == 0) begin
        fail_count++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result fwd=%0d rev=%0d en(f,r,h)=%b%b%b rej=%b",
                   got.fwd_duty, got.rev_duty, got.fwd_en, got.rev_en, got.hard_en,
                   got.rejected);
        end
      end else begin
        want = expected_outputs.pop_front();
        if (got.fwd_duty !== want.fwd_duty || got.rev_duty !== want.rev_duty ||
            got.fwd_en !== want.fwd_en || got.rev_en !== want.rev_en ||
            got.hard_en !== want.hard_en || got.rejected !== want.rejected) begin
          fail_count++;
          if (reported < 10) begin
            reported++;
            $display("result %0d: expected fwd=%0d rev=%0d en(f,r,h)=%b%b%b rej=%b",
                     outputs_checked, want.fwd_duty, want.rev_duty, want.fwd_en,
                     want.rev_en, want.hard_en, want.rejected);
            $display("result %0d: got      fwd=%0d rev=%0d en(f,r,h)=%b%b%b rej=%b",
                     outputs_checked, got.fwd_duty, got.rev_duty, got.fwd_en,
                     got.rev_en, got.hard_en, got.rejected);
          end
        end
      end
      outputs_checked++;
    end
    // One long hold-off lets the core fill up and push back on its input.
    if (!rx_hold_done && outputs_checked >= 500) begin
      rx_hold_left = 400;
      rx_hold_done = 1'b1;
    end
    quiet = (outputs_checked % 1000) >= 700 && (outputs_checked % 1000) < 900;
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 37);
    end
  end

  // Writes one register and mirrors it in the shadow copy once taken.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_WIRE_MODE) mode_sel = val[0];
    else inc_sel = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic mode, input logic [INC_W-1:0] inc);
    write_reg(REG_WIRE_MODE, CFG_DATA_W'(mode));
    write_reg(REG_STEP_INC, inc);
  endtask

  task automatic queue_press(input bit dir, input int sample, input bit valid);
    press_t p;
    p.press_forward = dir;
    p.trim_sample   = TRIM_W'(sample);
    p.trim_valid    = valid;
    pending_presses.push_back(p);
    presses_queued++;
  endtask

  // The sender stays quiet until every queued press has produced its result.
  task automatic wait_for_outputs();
    while (outputs_checked != presses_queued) @(posedge clk);
  endtask

  // A press that falls back on the held trim, so after a zero trim the step can move without any duty.
  task automatic queue_idle_trim_press(input bit dir);
    if ($urandom_range(1) == 1) queue_press(dir, 0, 1'b1);
    else queue_press(dir, $urandom_range(1023), 1'b0);
  endtask

  initial begin
    bit dir;
    int pick;
    int sample;
    logic mode;
    logic [INC_W-1:0] inc;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Two-wire at the reset increment: fallback trim, floor, idle step, reverse sign.
    set_config(MODE_TWO_WIRE, 8'd15);
    queue_press(PRESS_FWD, 0, 1'b1);
    queue_press(PRESS_FWD, 1023, 1'b1);
    queue_press(PRESS_REV, 1023, 1'b0);
    queue_press(PRESS_REV, 8, 1'b1);
    queue_press(PRESS_REV, 0, 1'b0);
    queue_press(PRESS_REV, 512, 1'b1);
    queue_press(PRESS_FWD, 1023, 1'b1);
    queue_press(PRESS_FWD, 1023, 1'b1);
    queue_press(PRESS_FWD, 16, 1'b1);
    queue_press(PRESS_FWD, 15, 1'b1);
    wait_for_outputs();

    // Three-wire at full increment: floor at zero, hard enable, duty overflow.
    set_config(MODE_THREE_WIRE, 8'd255);
    queue_press(PRESS_REV, 1023, 1'b1);
    queue_press(PRESS_FWD, 1023, 1'b1);
    queue_press(PRESS_FWD, 1023, 1'b1);
    queue_press(PRESS_FWD, 1023, 1'b1);
    queue_press(PRESS_FWD, 16, 1'b1);
    queue_press(PRESS_FWD, 0, 1'b1);
    repeat (4) queue_press(PRESS_REV, 0, 1'b0);
    wait_for_outputs();

    // A zero increment gives no duty at all.
    set_config(MODE_TWO_WIRE, 8'd0);
    queue_press(PRESS_FWD, 1023, 1'b1);
    queue_press(PRESS_FWD, 1023, 1'b1);
    queue_press(PRESS_REV, 1023, 1'b1);
    queue_press(PRESS_REV, 0, 1'b0);
    queue_press(PRESS_REV, 0, 1'b0);
    wait_for_outputs();

    // Random runs of presses over several settings; direction tends to persist.
    dir = PRESS_FWD;
    for (int k = 0; k < 6; k++) begin
      mode = k[0] ? MODE_THREE_WIRE : MODE_TWO_WIRE;
      if (k < 2) inc = 8'd1;
      else if (k < 4) inc = 8'd255;
      else inc = INC_W'($urandom_range(1, 254));
      set_config(mode, inc);
      repeat (180) begin
        if ($urandom_range(99) < 20) dir = ~dir;
        pick = $urandom_range(9);
        if (pick == 0) sample = 0;
        else if (pick == 1) sample = $urandom_range(1, 15);
        else if (pick == 2) sample = 1023;
        else if (pick == 3) sample = $urandom_range(16, 63);
        else sample = $urandom_range(1023);
        queue_press(dir, sample, $urandom_range(9) != 0);
      end
      wait_for_outputs();
    end

    // With a zero trim the step walks below zero without any duty.
    set_config(MODE_TWO_WIRE, 8'd1);
    queue_press(PRESS_REV, 5, 1'b1);
    repeat (step_now + 3) queue_idle_trim_press(PRESS_REV);
    wait_for_outputs();

    // Switching to three-wire with a negative step left over.
    set_config(MODE_THREE_WIRE, 8'd200);
    queue_press(PRESS_REV, 0, 1'b0);
    queue_press(PRESS_REV, 1023, 1'b1);
    queue_press(PRESS_FWD, 64, 1'b1);
    queue_press(PRESS_FWD, 0, 1'b0);
    wait_for_outputs();

    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_outputs.size() == 0) begin
      $display("bidirectional_fan_step_pwm_core_tb: PASS");
    end else begin
      $display("bidirectional_fan_step_pwm_core_tb: FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("bidirectional_fan_step_pwm_core_tb: FAIL");
    $finish;
  end

endmodule
